// ===== src/drl_pkg.sv =====
// drl_pkg: shared widths, register indexes and reset values for the dda line rasterizer
// no dependencies; imported by the rasterizer top level and its checker
`default_nettype none

package drl_pkg;

   localparam int PORT_COORD_BITS = 6;
   localparam int COLOR_BITS      = 8;
   localparam int FRAME_BITS      = 7;

   typedef logic [COLOR_BITS-1:0]      color_type;
   typedef logic [FRAME_BITS-1:0]      frame_type;
   typedef logic [PORT_COORD_BITS-1:0] port_coord_type;

   // configuration register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam frame_type FRAME_WIDTH_RESET  = 7'd64;
   localparam frame_type FRAME_HEIGHT_RESET = 7'd64;

endpackage

`default_nettype wire

// ===== src/dda_line_rasterizer_unit.sv =====
// the item is latched, the setup state derives the walk terms, then the run state loads
// one pixel per cycle into the output reg, while rsp_stall lets it drain, from a single
//   error-accumulator add/compare step unit; n + 1 pixels per item, n = longer-axis span (0..63)
// req_stall is high from the cycle after acceptance until the last pixel enters the output reg
// reset (synchronous, active high): sequencer idle, output empty, frame size 64 x 64
// depends on drl_pkg
`default_nettype none

module dda_line_rasterizer_unit
   import drl_pkg::*;
#(
   parameter int COORD_BITS = 6
) (
   input  wire logic           clock,
   input  wire logic           reset,
   // line command items
   input  wire logic           req_valid,
   output      logic           req_stall,
   input  wire port_coord_type req_start_x,
   input  wire port_coord_type req_start_y,
   input  wire port_coord_type req_end_x,
   input  wire port_coord_type req_end_y,
   input  wire color_type      req_fore_color,
   input  wire color_type      req_back_color,
   input  wire color_type      req_glyph,
   // pixel items
   output      logic           rsp_valid,
   input  wire logic           rsp_stall,
   output      port_coord_type rsp_pixel_x,
   output      port_coord_type rsp_pixel_y,
   output      color_type      rsp_out_fore,
   output      color_type      rsp_out_back,
   output      color_type      rsp_out_glyph,
   output      logic           rsp_in_frame,
   output      logic           rsp_last_pixel,
   // configuration writes
   input  wire logic           csr_write,
   input  wire logic           csr_index,
   input  wire frame_type      csr_data
);

   localparam int CB = COORD_BITS;   // internal coordinate width
   localparam int RB = COORD_BITS + 1; // remainder width, r < 2n
   localparam int SB = COORD_BITS + 2; // remainder plus 2m

   // sequencer codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   // control registers
   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   frame_type  frame_width_ff, frame_width_in;
   frame_type  frame_height_ff, frame_height_in;

   // latched command
   logic [CB-1:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   color_type     fore_ff, fore_in, back_ff, back_in, glyph_ff, glyph_in;

   // walk state
   logic [CB-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CB-1:0] k_ff, k_in, n_ff, n_in, m_ff, m_in;
   logic [RB-1:0] r_ff, r_in;
   logic          x_major_ff, x_major_in;
   logic          y_neg_ff, y_neg_in;

   // output register
   port_coord_type rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   color_type      rsp_fore_ff, rsp_fore_in, rsp_back_ff, rsp_back_in;
   color_type      rsp_glyph_ff, rsp_glyph_in;
   logic           rsp_in_frame_ff, rsp_in_frame_in;
   logic           rsp_last_ff, rsp_last_in;

   // setup and step terms
   logic          req_accept;
   logic          out_load;
   logic          is_last;
   logic          swap;
   logic [CB-1:0] ax, ay, bx, by, dx, ady;
   logic          dy_neg, x_major_set;
   logic [SB-1:0] acc_sum, two_n;
   logic          carry;
   logic          step_x, step_y;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   // in the run state the output register takes a pixel whenever it is empty or being drained
   assign out_load   = (state_ff == ST_RUN) && (!rsp_valid_ff || !rsp_stall);
   assign is_last    = (k_ff == n_ff);

   // endpoint ordering: vertical lines by y, all others by x
   assign swap   = (sx_ff == ex_ff) ? (sy_ff > ey_ff) : (sx_ff > ex_ff);
   assign ax     = swap ? ex_ff : sx_ff;
   assign ay     = swap ? ey_ff : sy_ff;
   assign bx     = swap ? sx_ff : ex_ff;
   assign by     = swap ? sy_ff : ey_ff;
   assign dx     = bx - ax;
   assign dy_neg = (by < ay);
   assign ady    = dy_neg ? (ay - by) : (by - ay);
   // shallow lines (including a single point) step along x
   assign x_major_set = (ady <= dx);

   // shared step unit: remainder of (2km + n) mod 2n, carry bumps the minor axis
   assign acc_sum = SB'(r_ff) + SB'({m_ff, 1'b0});
   assign two_n   = SB'({n_ff, 1'b0});
   assign carry   = (acc_sum >= two_n);
   assign step_x  = x_major_ff || carry;
   assign step_y  = !x_major_ff || carry;

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;

      sx_in    = sx_ff;
      sy_in    = sy_ff;
      ex_in    = ex_ff;
      ey_in    = ey_ff;
      fore_in  = fore_ff;
      back_in  = back_ff;
      glyph_in = glyph_ff;

      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      m_in       = m_ff;
      r_in       = r_ff;
      x_major_in = x_major_ff;
      y_neg_in   = y_neg_ff;

      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_fore_in     = rsp_fore_ff;
      rsp_back_in     = rsp_back_ff;
      rsp_glyph_in    = rsp_glyph_ff;
      rsp_in_frame_in = rsp_in_frame_ff;
      rsp_last_in     = rsp_last_ff;

      // configuration
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            default:          ;
         endcase
      end

      // output register drains independently of the sequencer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // endpoint bits above the coordinate width are dropped
               sx_in    = req_start_x[CB-1:0];
               sy_in    = req_start_y[CB-1:0];
               ex_in    = req_end_x[CB-1:0];
               ey_in    = req_end_y[CB-1:0];
               fore_in  = req_fore_color;
               back_in  = req_back_color;
               glyph_in = req_glyph;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cur_x_in   = ax;
            cur_y_in   = ay;
            k_in       = '0;
            n_in       = x_major_set ? dx : ady;
            m_in       = x_major_set ? ady : dx;
            r_in       = RB'(x_major_set ? dx : ady);
            x_major_in = x_major_set;
            y_neg_in   = dy_neg;
            state_in   = ST_RUN;
         end
         ST_RUN: begin
            if (out_load) begin
               rsp_valid_in    = 1'b1;
               rsp_x_in        = PORT_COORD_BITS'(cur_x_ff);
               rsp_y_in        = PORT_COORD_BITS'(cur_y_ff);
               rsp_fore_in     = fore_ff;
               rsp_back_in     = back_ff;
               rsp_glyph_in    = glyph_ff;
               rsp_in_frame_in = (FRAME_BITS'(cur_x_ff) < frame_width_ff) &&
                                 (FRAME_BITS'(cur_y_ff) < frame_height_ff);
               rsp_last_in     = is_last;

               // advance one step along the line
               k_in = k_ff + 1'b1;
               r_in = carry ? RB'(acc_sum - two_n) : RB'(acc_sum);
               if (step_x) begin
                  cur_x_in = cur_x_ff + 1'b1;
               end
               if (step_y) begin
                  cur_y_in = y_neg_ff ? (cur_y_ff - 1'b1) : (cur_y_ff + 1'b1);
               end
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      sx_ff           <= sx_in;
      sy_ff           <= sy_in;
      ex_ff           <= ex_in;
      ey_ff           <= ey_in;
      fore_ff         <= fore_in;
      back_ff         <= back_in;
      glyph_ff        <= glyph_in;
      cur_x_ff        <= cur_x_in;
      cur_y_ff        <= cur_y_in;
      k_ff            <= k_in;
      n_ff            <= n_in;
      m_ff            <= m_in;
      r_ff            <= r_in;
      x_major_ff      <= x_major_in;
      y_neg_ff        <= y_neg_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
      rsp_fore_ff     <= rsp_fore_in;
      rsp_back_ff     <= rsp_back_in;
      rsp_glyph_ff    <= rsp_glyph_in;
      rsp_in_frame_ff <= rsp_in_frame_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = rsp_x_ff;
   assign rsp_pixel_y    = rsp_y_ff;
   assign rsp_out_fore   = rsp_fore_ff;
   assign rsp_out_back   = rsp_back_ff;
   assign rsp_out_glyph  = rsp_glyph_ff;
   assign rsp_in_frame   = rsp_in_frame_ff;
   assign rsp_last_pixel = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/drl_checker.sv =====
// drl_checker: port-level assertions for the dda line rasterizer, bound to the top level
// depends on drl_pkg and dda_line_rasterizer_unit
`default_nettype none

module drl_checker
   import drl_pkg::*;
(
   input wire logic           clock,
   input wire logic           reset,
   input wire logic           req_valid,
   input wire logic           req_stall,
   input wire logic           rsp_valid,
   input wire logic           rsp_stall,
   input wire port_coord_type rsp_pixel_x,
   input wire logic           rsp_last_pixel
);

   // an accepted item keeps the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block took a second item right after accepting one");

   // mid-line pixels are followed without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_pixel |=> rsp_valid)
      else $error("pixel run has a gap");

   // when ready for a new item, only a final pixel may still be pending
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      !req_stall && rsp_valid |-> rsp_last_pixel)
      else $error("ready while a line is still being drawn");

   // x never decreases and moves by at most one within a line
   a_x_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_pixel |=>
         (rsp_pixel_x == $past(rsp_pixel_x)) ||
         (rsp_pixel_x == $past(rsp_pixel_x) + 6'd1))
      else $error("x step out of range");

endmodule

bind dda_line_rasterizer_unit drl_checker u_drl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pixel_x    (rsp_pixel_x),
   .rsp_last_pixel (rsp_last_pixel)
);

`default_nettype wire

// ===== tb/tb_dda_line_rasterizer_unit.sv =====
// testbench for dda_line_rasterizer_unit: line command items in, one pixel item per point out
// predicts every pixel with an integer dda model and checks them in order; needs drl_pkg
`timescale 1ns / 100ps

module tb_dda_line_rasterizer_unit;
   import drl_pkg::*;

   localparam int NUM_PHASES     = 8;    // random phases after the directed one
   localparam int LINES_PER_PHASE = 26;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 3000; // quiet cycles; above the long receiver hold
   localparam int LONG_HOLD      = 400;
   localparam int LONG_HOLD_AT   = 1500; // pixels seen before the long hold starts

   typedef struct packed {
      port_coord_type sx;
      port_coord_type sy;
      port_coord_type ex;
      port_coord_type ey;
      color_type      fore;
      color_type      back;
      color_type      glyph;
   } line_cmd_t;

   typedef struct packed {
      port_coord_type x;
      port_coord_type y;
      color_type      fore;
      color_type      back;
      color_type      glyph;
      logic           in_frame;
      logic           last;
   } pixel_item_t;

   logic           clock;
   logic           reset          = 1'b1;
   logic           req_valid      = 1'b0;
   logic           req_stall;
   port_coord_type req_start_x    = '0;
   port_coord_type req_start_y    = '0;
   port_coord_type req_end_x      = '0;
   port_coord_type req_end_y      = '0;
   color_type      req_fore_color = '0;
   color_type      req_back_color = '0;
   color_type      req_glyph      = '0;
   logic           rsp_valid;
   logic           rsp_stall      = 1'b0;
   port_coord_type rsp_pixel_x;
   port_coord_type rsp_pixel_y;
   color_type      rsp_out_fore;
   color_type      rsp_out_back;
   color_type      rsp_out_glyph;
   logic           rsp_in_frame;
   logic           rsp_last_pixel;
   logic           csr_write      = 1'b0;
   logic           csr_index      = CSR_FRAME_WIDTH;
   frame_type      csr_data       = '0;

   dda_line_rasterizer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_fore_color (req_fore_color),
      .req_back_color (req_back_color),
      .req_glyph      (req_glyph),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_out_fore   (rsp_out_fore),
      .rsp_out_back   (rsp_out_back),
      .rsp_out_glyph  (rsp_out_glyph),
      .rsp_in_frame   (rsp_in_frame),
      .rsp_last_pixel (rsp_last_pixel),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // shadow copy of the frame registers, only changed while the block is idle
   frame_type   frame_w = FRAME_WIDTH_RESET;
   frame_type   frame_h = FRAME_HEIGHT_RESET;

   line_cmd_t   pending_lines[$];   // line items not yet offered
   pixel_item_t expected_pixels[$]; // predicted pixels, oldest first
   line_cmd_t   cur_line;

   logic        calm = 1'b0;        // no idling on either side in the last phase
   int          send_gap = 0;
   int          recv_gap = 0;
   int          long_hold = 0;
   bit          long_hold_done = 1'b0;
   int          lines_accepted = 0;
   int          pixels_seen = 0;
   int          mismatches = 0;
   int          settings_run = 1;
   int          quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // round num/den half away from zero, den > 0
   function automatic int round_half_away(input int num, input int den);
      if (num >= 0) return (2 * num + den) / (2 * den);
      return -((2 * (-num) + den) / (2 * den));
   endfunction

   function automatic void push_pixel(input int px, input int py, input line_cmd_t c,
                                      input bit last);
      pixel_item_t p;
      p.x        = port_coord_type'(px);
      p.y        = port_coord_type'(py);
      p.fore     = c.fore;
      p.back     = c.back;
      p.glyph    = c.glyph;
      // compared before truncation, so a frame size above 64 flags nothing
      p.in_frame = (px < int'(frame_w)) && (py < int'(frame_h));
      p.last     = last;
      expected_pixels = {expected_pixels, p};
   endfunction

   // expected pixel run of one line item
   function automatic void rasterize_line(input line_cmd_t c);
      int x1, y1, x2, y2, dx, dy, ady, n, k, t, lo, hi, px, py;
      x1 = c.sx;
      y1 = c.sy;
      x2 = c.ex;
      y2 = c.ey;
      if (x1 == x2) begin
         // vertical: always walk upward in y
         lo = (y1 < y2) ? y1 : y2;
         hi = (y1 < y2) ? y2 : y1;
         for (k = lo; k <= hi; k++) push_pixel(x1, k, c, k == hi);
      end else begin
         if (x1 > x2) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
         end
         dx  = x2 - x1;
         dy  = y2 - y1;
         ady = (dy < 0) ? -dy : dy;
         n   = (ady <= dx) ? dx : ady;
         for (k = 0; k <= n; k++) begin
            if (ady <= dx) begin
               // shallow: x is the driving axis
               px = x1 + k;
               py = y1 + round_half_away(k * dy, dx);
            end else begin
               // steep: y steps by the sign of dy
               py = (dy < 0) ? y1 - k : y1 + k;
               px = x1 + round_half_away(k * dx, ady);
            end
            push_pixel(px, py, c, k == n);
         end
      end
   endfunction

   task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                           input int fore, input int back, input int glyph);
      line_cmd_t c;
      c.sx    = port_coord_type'(sx);
      c.sy    = port_coord_type'(sy);
      c.ex    = port_coord_type'(ex);
      c.ey    = port_coord_type'(ey);
      c.fore  = color_type'(fore);
      c.back  = color_type'(back);
      c.glyph = color_type'(glyph);
      pending_lines = {pending_lines, c};
   endtask

   task automatic write_csr(input logic idx, input frame_type val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) frame_w = val;
      else frame_h = val;
   endtask

   // sender: one line item at a time from pending_lines, with random gaps
   always @(posedge clock) begin : drive_lines
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            rasterize_line(cur_line);
            lines_accepted++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_lines.size() > 0) begin
               cur_line = pending_lines.pop_front();
               req_start_x    <= cur_line.sx;
               req_start_y    <= cur_line.sy;
               req_end_x      <= cur_line.ex;
               req_end_y      <= cur_line.ey;
               req_fore_color <= cur_line.fore;
               req_back_color <= cur_line.back;
               req_glyph      <= cur_line.glyph;
               offer = 1'b1;
               // the gap follows once this item has been taken
               if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 14);
            end
         end
         req_valid <= offer;
      end
   end

   // receiver: check each pixel item against the oldest prediction, stall in bursts
   always @(posedge clock) begin : check_pixels
      pixel_item_t got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            pixels_seen++;
            got = '{rsp_pixel_x, rsp_pixel_y, rsp_out_fore, rsp_out_back, rsp_out_glyph,
                    rsp_in_frame, rsp_last_pixel};
            if (expected_pixels.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected pixel x=%0d y=%0d at %0t", got.x, got.y, $realtime);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("pixel mismatch at %0t (frame %0dx%0d)", $realtime,
                              frame_w, frame_h);
                     $display("  expected x=%0d y=%0d fore=%h back=%h glyph=%h in=%b last=%b",
                              want.x, want.y, want.fore, want.back, want.glyph,
                              want.in_frame, want.last);
                     $display("  actual   x=%0d y=%0d fore=%h back=%h glyph=%h in=%b last=%b",
                              got.x, got.y, got.fore, got.back, got.glyph,
                              got.in_frame, got.last);
                  end
                  mismatches++;
               end
            end
         end
         // one long hold so the block backs up and stalls its input
         if (long_hold > 0) begin
            long_hold--;
         end else if (!long_hold_done && pixels_seen >= LONG_HOLD_AT) begin
            long_hold      = LONG_HOLD;
            long_hold_done = 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            recv_gap = $urandom_range(1, 14);
         end
         rsp_stall <= (long_hold > 0) || (recv_gap > 0);
      end
   end

   // watchdog on cycles in which neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : run_phases
      int p, i, sel, sx, sy, ex, ey;
      frame_type cfg_w[NUM_PHASES];
      frame_type cfg_h[NUM_PHASES];

      // zero, one, exact 64 and oversized sizes on both axes
      cfg_w = '{7'd0,  7'd64, 7'd127, 7'd1, 7'd33, 7'd0,  7'd127, 7'd64};
      cfg_h = '{7'd64, 7'd0,  7'd127, 7'd1, 7'd17, 7'd0,  7'd0,   7'd64};
      cfg_w[5] = frame_type'($urandom_range(0, 127));
      cfg_h[5] = frame_type'($urandom_range(0, 127));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed lines under the reset frame size
      add_line(0, 0, 0, 0, 8'h00, 8'hff, 8'h00);      // single point at the origin
      add_line(63, 63, 63, 63, 8'hff, 8'h00, 8'hff);  // single point at the far corner
      add_line(0, 0, 63, 0, 8'haa, 8'h55, 8'h20);     // full horizontal
      add_line(63, 63, 0, 63, 8'h55, 8'haa, 8'h7f);   // horizontal given right to left
      add_line(10, 63, 10, 0, 8'h01, 8'h80, 8'h41);   // vertical given top down
      add_line(0, 0, 0, 63, 8'hff, 8'hff, 8'hff);     // full vertical
      add_line(0, 0, 63, 63, 8'h12, 8'h34, 8'h56);    // rising diagonal
      add_line(63, 0, 0, 63, 8'h9a, 8'hbc, 8'hde);    // falling diagonal
      add_line(5, 0, 8, 63, 8'h00, 8'h00, 8'h00);     // steep, rising
      add_line(40, 60, 30, 2, 8'h0f, 8'hf0, 8'h3c);   // steep, rising, swapped
      add_line(0, 10, 63, 12, 8'hc3, 8'h3c, 8'h81);   // shallow
      add_line(0, 0, 2, 1, 8'h11, 8'h22, 8'h33);      // exact half rounds up
      add_line(0, 1, 2, 0, 8'h44, 8'h55, 8'h66);      // negative half rounds away
      add_line(0, 0, 1, 2, 8'h77, 8'h88, 8'h99);      // steep half
      add_line(1, 0, 0, 2, 8'haa, 8'hbb, 8'hcc);      // steep half, x falling
      add_line(63, 1, 0, 0, 8'hdd, 8'hee, 8'hff);     // long shallow, swapped
      add_line(62, 63, 63, 0, 8'h01, 8'h02, 8'h04);   // steep one column over
      add_line(3, 7, 9, 7, 8'h08, 8'h10, 8'h40);      // short horizontal
      add_line(0, 63, 63, 0, 8'h80, 8'h7f, 8'h01);    // falling diagonal from the top
      add_line(31, 32, 32, 31, 8'hfe, 8'hef, 8'h5a);  // two pixel diagonal

      for (p = 0; p <= NUM_PHASES; p++) begin
         if (p > 0) begin
            write_csr(CSR_FRAME_WIDTH, cfg_w[p-1]);
            write_csr(CSR_FRAME_HEIGHT, cfg_h[p-1]);
            settings_run++;
            @(negedge clock);
            if (p == NUM_PHASES) calm = 1'b1;
            for (i = 0; i < LINES_PER_PHASE; i++) begin
               sel = $urandom_range(0, 9);
               sx  = $urandom_range(0, 63);
               sy  = $urandom_range(0, 63);
               ex  = $urandom_range(0, 63);
               ey  = $urandom_range(0, 63);
               case (sel) inside
                  [0:2]: begin
                     // short line, wrapping at the coordinate edge
                     ex = (sx + $urandom_range(0, 8) - 4) & 63;
                     ey = (sy + $urandom_range(0, 8) - 4) & 63;
                  end
                  3: ey = sy;
                  4: ex = sx;
                  5: begin
                     // corners and edges
                     sx = 63 * $urandom_range(0, 1);
                     sy = 63 * $urandom_range(0, 1);
                     ex = 63 * $urandom_range(0, 1);
                     ey = 63 * $urandom_range(0, 1);
                  end
                  6: begin
                     ex = sx;
                     ey = sy;
                  end
                  default: ;
               endcase
               add_line(sx, sy, ex, ey, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
            end
         end
         // phase ends when every line is taken and every pixel has come back
         do @(negedge clock);
         while (pending_lines.size() != 0 || req_valid || expected_pixels.size() != 0);
         repeat (DRAIN_CYCLES) @(negedge clock);
      end

      if (expected_pixels.size() != 0) begin
         $display("%0d predicted pixels never arrived", expected_pixels.size());
         mismatches += expected_pixels.size();
      end
      $display("covered %0d line items and %0d pixel items over %0d frame settings",
               lines_accepted, pixels_seen, settings_run);
      $display("mismatching pixel items: %0d", mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
